>>> rtl/core/bqedt_pkg.sv
`timescale 1ns / 1ps
package bqedt_pkg;

    localparam int FAM_W    = 2;
    localparam int ADDR_W   = 64;
    localparam int TIME_W   = 32;
    localparam int META_W   = FAM_W + TIME_W;
    localparam int LIVE_W   = 6;
    localparam int DROP_W   = 32;
    localparam int S_DATA_W = 200;
    localparam int M_DATA_W = 200;

    localparam logic [FAM_W-1:0] FAM_NONE = 2'd0;
    localparam logic [FAM_W-1:0] FAM_RSVD = 2'd3;

    localparam logic CMD_BAN  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_Q_CHK,
        ST_T_RD,
        ST_T_CHK,
        ST_T_INS,
        ST_E_RD,
        ST_E_CHK,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic enq;
        logic latch_now;
        logic q_rd;
        logic q_pop;
        logic slot_rst;
        logic slot_inc;
        logic t_rd;
        logic t_scan;
        logic t_wr;
        logic t_ins;
        logic t_clr;
        logic emit;
        logic emit_sum;
    } cmd_t;

    typedef struct packed {
        logic q_empty;
        logic q_live;
        logic slot_last;
        logic t_valid;
        logic t_match;
        logic t_live;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/core/bqedt_ctrl.sv
`timescale 1ns / 1ps
module bqedt_ctrl
    import bqedt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  logic  in_cmd,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_cmd == CMD_TICK) begin
                        cmd.latch_now = 1'b1;
                        state_next    = ST_DRAIN;
                    end else begin
                        cmd.enq = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (stat.q_empty) begin
                    cmd.slot_rst = 1'b1;
                    state_next   = ST_E_RD;
                end else begin
                    cmd.q_rd   = 1'b1;
                    state_next = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                cmd.q_pop = 1'b1;
                if (stat.q_live) begin
                    cmd.slot_rst = 1'b1;
                    state_next   = ST_T_RD;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_T_RD: begin
                cmd.t_rd   = 1'b1;
                state_next = ST_T_CHK;
            end
            ST_T_CHK: begin
                cmd.t_scan = 1'b1;
                if (stat.t_match) begin
                    cmd.t_wr   = 1'b1;
                    state_next = ST_DRAIN;
                end else if (stat.slot_last) begin
                    state_next = ST_T_INS;
                end else begin
                    cmd.slot_inc = 1'b1;
                    state_next   = ST_T_RD;
                end
            end
            ST_T_INS: begin
                cmd.t_ins  = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_E_RD: begin
                cmd.t_rd   = 1'b1;
                state_next = ST_E_CHK;
            end
            ST_E_CHK: begin
                // hold on a live slot until the output register frees up
                if (!(stat.t_valid && stat.t_live && !stat.out_free)) begin
                    if (stat.t_valid && !stat.t_live) cmd.t_clr = 1'b1;
                    if (stat.t_valid && stat.t_live)  cmd.emit  = 1'b1;
                    if (stat.slot_last) begin
                        state_next = ST_SUM;
                    end else begin
                        cmd.slot_inc = 1'b1;
                        state_next   = ST_E_RD;
                    end
                end
            end
            ST_SUM: begin
                if (stat.out_free) begin
                    cmd.emit_sum = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/bqedt_dp.sv
`timescale 1ns / 1ps
module bqedt_dp
    import bqedt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] in_data,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [FAM_W-1:0]  in_fam;
    logic [ADDR_W-1:0] in_hi, in_lo;
    logic [TIME_W-1:0] in_exp, in_now;

    assign in_fam = in_data[1:0];
    assign in_hi  = in_data[65:2];
    assign in_lo  = in_data[129:66];
    assign in_exp = in_data[161:130];
    assign in_now = in_data[193:162];

    logic [ADDR_W-1:0] q_hi_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] q_lo_mem [QUEUE_DEPTH];
    logic [META_W-1:0] q_meta_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] t_hi_mem [QUEUE_DEPTH];
    logic [ADDR_W-1:0] t_lo_mem [QUEUE_DEPTH];
    logic [META_W-1:0] t_meta_mem [QUEUE_DEPTH];

    logic [AW-1:0]        head_reg, tail_reg, slot_reg, free_reg;
    logic [CW-1:0]        count_reg;
    logic                 free_found_reg;
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [DROP_W-1:0]    drop_reg;
    logic [LIVE_W-1:0]    live_reg;
    logic [TIME_W-1:0]    now_reg;

    logic [ADDR_W-1:0] q_hi_reg, q_lo_reg, t_hi_reg, t_lo_reg;
    logic [META_W-1:0] q_meta_reg, t_meta_reg;

    logic              out_valid_reg, out_entry_reg, out_last_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic ban_ok, q_full, t_wr_en;
    logic [AW-1:0] t_wr_addr;

    always_comb begin
        ban_ok    = !(in_fam inside {FAM_NONE, FAM_RSVD});
        q_full    = (count_reg == FULL_CNT);
        t_wr_addr = cmd.t_ins ? free_reg : slot_reg;
        t_wr_en   = cmd.t_wr || (cmd.t_ins && free_found_reg);
    end

    assign stat.q_empty   = (count_reg == '0);
    assign stat.q_live    = q_meta_reg[TIME_W-1:0] > now_reg;
    assign stat.slot_last = (slot_reg == LAST_IDX);
    assign stat.t_valid   = valid_reg[slot_reg];
    assign stat.t_match   = valid_reg[slot_reg] && (t_meta_reg[META_W-1:TIME_W]
                            == q_meta_reg[META_W-1:TIME_W]) && (t_hi_reg == q_hi_reg)
                            && (t_lo_reg == q_lo_reg);
    assign stat.t_live    = t_meta_reg[TIME_W-1:0] > now_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

    // queue storage
    always_ff @(posedge aclk) begin
        if (cmd.enq && ban_ok && !q_full) begin
            q_hi_mem[head_reg]   <= in_hi;
            q_lo_mem[head_reg]   <= in_lo;
            q_meta_mem[head_reg] <= {in_fam, in_exp};
        end
        if (cmd.q_rd) begin
            q_hi_reg   <= q_hi_mem[tail_reg];
            q_lo_reg   <= q_lo_mem[tail_reg];
            q_meta_reg <= q_meta_mem[tail_reg];
        end
    end

    // table storage
    always_ff @(posedge aclk) begin
        if (t_wr_en) begin
            t_hi_mem[t_wr_addr]   <= q_hi_reg;
            t_lo_mem[t_wr_addr]   <= q_lo_reg;
            t_meta_mem[t_wr_addr] <= q_meta_reg;
        end
        if (cmd.t_rd) begin
            t_hi_reg   <= t_hi_mem[slot_reg];
            t_lo_reg   <= t_lo_mem[slot_reg];
            t_meta_reg <= t_meta_mem[slot_reg];
        end
        if (cmd.latch_now) now_reg <= in_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            drop_reg       <= '0;
            slot_reg       <= '0;
            free_reg       <= '0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            live_reg       <= '0;
        end else begin
            if (cmd.enq && ban_ok) begin
                if (q_full) begin
                    drop_reg <= drop_reg + 1'b1;
                end else begin
                    head_reg  <= (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.q_pop) begin
                tail_reg  <= (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.latch_now) live_reg <= '0;
            if (cmd.slot_rst) begin
                slot_reg       <= '0;
                free_found_reg <= 1'b0;
            end
            if (cmd.slot_inc) slot_reg <= slot_reg + 1'b1;
            // remember the lowest empty slot seen in this scan
            if (cmd.t_scan && !valid_reg[slot_reg] && !free_found_reg) begin
                free_reg       <= slot_reg;
                free_found_reg <= 1'b1;
            end
            if (t_wr_en) valid_reg[t_wr_addr] <= 1'b1;
            if (cmd.t_clr) valid_reg[slot_reg] <= 1'b0;
            if (cmd.emit) live_reg <= live_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_sum) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_entry_reg <= 1'b1;
            out_last_reg  <= 1'b0;
            out_data_reg  <= {DROP_W'(0), LIVE_W'(0),
                              t_meta_reg[TIME_W-1:0] - now_reg,
                              t_lo_reg, t_hi_reg, t_meta_reg[META_W-1:TIME_W]};
        end else if (cmd.emit_sum) begin
            out_entry_reg <= 1'b0;
            out_last_reg  <= 1'b1;
            out_data_reg  <= {drop_reg, live_reg, TIME_W'(0), ADDR_W'(0),
                              ADDR_W'(0), FAM_W'(0)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_entry_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/core/ban_queue_expiring_decision_table_core.sv
`timescale 1ns / 1ps
// Channel  Ports                          Content
// s_       tvalid tready tdata tuser      ban (tuser 0) or tick (tuser 1)
// m_       tvalid tready tdata tuser tlast live entry (tuser 1) or summary (tlast 1)
//
// A ban is taken without leaving the idle state. A tick drains the ring ban by ban
// through the drain and check states; a live ban then reads table slots, a read and
// a check state each, until a match, or scans every slot and then passes the insert
// state. The empty-ring check leads to the emit sweep, read and check per slot, then
// the summary; s_tready stays low for the whole tick. Reset clears pointers,
// counters and slot valid bits at once. Stalls on m_ hold the sweep in place.
module ban_queue_expiring_decision_table_core
    import bqedt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // addr_family, addr_hi, addr_lo, expiry_time, now_time, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // command
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_family, out_addr_hi, out_addr_lo, ttl_seconds, live_count, drop_count
    output logic [M_DATA_W-1:0] m_tdata,
    // entry_valid
    output logic                m_tuser,
    output logic                m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    bqedt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bqedt_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/sv/tb_ban_queue_expiring_decision_table_core.sv
`timescale 1ns / 1ps
module tb_ban_queue_expiring_decision_table_core;
    import bqedt_pkg::*;

    localparam int DEPTH = 32;

    typedef struct {
        logic              entry;
        logic [FAM_W-1:0]  fam;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [TIME_W-1:0] ttl;
        logic [LIVE_W-1:0] live;
        logic [DROP_W-1:0] drop;
        logic              last;
    } decision_t;

    typedef struct {
        logic [FAM_W-1:0]  fam;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [TIME_W-1:0] expiry;
    } ban_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    ban_queue_expiring_decision_table_core #(.QUEUE_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // predictor state
    ban_t        pending_bans[$];
    ban_t        ban_slots[DEPTH];
    logic [31:0] bans_dropped;
    decision_t   expected_decisions[$];

    int  errors;
    int  items_sent;
    bit  quiet;
    int  long_hold;
    logic [TIME_W-1:0] clock_now;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void upsert_slot(ban_t b);
        int open_idx;
        open_idx = DEPTH;
        for (int i = 0; i < DEPTH; i++) begin
            if (ban_slots[i].expiry == 0) begin
                if (open_idx == DEPTH) open_idx = i;
            end else if (ban_slots[i].fam == b.fam && ban_slots[i].hi == b.hi &&
                         ban_slots[i].lo == b.lo) begin
                ban_slots[i] = b;
                return;
            end
        end
        if (open_idx != DEPTH) ban_slots[open_idx] = b;
    endfunction

    function automatic void predict_item(logic cmd, ban_t b, logic [TIME_W-1:0] now);
        decision_t d;
        int live;
        if (cmd == CMD_BAN) begin
            if (b.fam == FAM_NONE || b.fam == FAM_RSVD) return;
            if (pending_bans.size() >= DEPTH) bans_dropped++;
            else pending_bans.push_back(b);
            return;
        end
        while (pending_bans.size() > 0) begin
            b = pending_bans.pop_front();
            if (b.expiry > now) upsert_slot(b);
        end
        live = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (ban_slots[i].expiry != 0 && ban_slots[i].expiry <= now)
                ban_slots[i].expiry = 0;
            if (ban_slots[i].expiry != 0) begin
                live++;
                d = '{1'b1, ban_slots[i].fam, ban_slots[i].hi, ban_slots[i].lo,
                      ban_slots[i].expiry - now, '0, '0, 1'b0};
                expected_decisions.push_back(d);
            end
        end
        d = '{1'b0, '0, '0, '0, '0, live[LIVE_W-1:0], bans_dropped, 1'b1};
        expected_decisions.push_back(d);
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic cmd, logic [FAM_W-1:0] fam, logic [ADDR_W-1:0] hi,
                             logic [ADDR_W-1:0] lo, logic [TIME_W-1:0] expiry,
                             logic [TIME_W-1:0] now);
        ban_t b;
        b = '{fam, hi, lo, expiry};
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, now, expiry, lo, hi, fam};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(cmd, b, now);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic ban(logic [FAM_W-1:0] fam, logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo,
                       logic [TIME_W-1:0] expiry);
        send_item(CMD_BAN, fam, hi, lo, expiry, $urandom);
    endtask

    task automatic tick(logic [TIME_W-1:0] now);
        send_item(CMD_TICK, FAM_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, now);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        decision_t d;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_decisions.size() == 0) begin
                $error("unexpected result item");
                errors++;
            end else begin
                d = expected_decisions.pop_front();
                check_field("entry_valid", 64'(d.entry), 64'(m_tuser));
                check_field("out_family", 64'(d.fam), 64'(m_tdata[1:0]));
                check_field("out_addr_hi", d.hi, m_tdata[65:2]);
                check_field("out_addr_lo", d.lo, m_tdata[129:66]);
                check_field("ttl_seconds", 64'(d.ttl), 64'(m_tdata[161:130]));
                check_field("live_count", 64'(d.live), 64'(m_tdata[167:162]));
                check_field("drop_count", 64'(d.drop), 64'(m_tdata[199:168]));
                check_field("last", 64'(d.last), 64'(m_tlast));
            end
        end
    end

    // result side backpressure
    initial begin
        int burst;
        burst = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_special_cases();
        ban(FAM_NONE, 64'h1, 64'h2, 32'd100);
        ban(FAM_RSVD, 64'h1, 64'h2, 32'd100);
        tick(32'd0);
        ban(2'd1, '0, '0, 32'd0);
        ban(2'd1, '0, 64'hFFFF_FFFF, 32'd5);
        ban(2'd2, '1, '1, 32'hFFFF_FFFF);
        ban(2'd1, '0, 64'hC0A8_0001, 32'd50);
        ban(2'd2, '0, 64'hC0A8_0001, 32'd60);
        ban(2'd1, '0, 64'hC0A8_0001, 32'd80);
        tick(32'd5);
        ban(2'd2, '1, '1, 32'd7);
        tick(32'd6);
        tick(32'hFFFF_FFFE);
        tick(32'hFFFF_FFFF);
    endtask

    task automatic test_ring_overflow();
        for (int i = 0; i < DEPTH + 3; i++) ban(2'd1, '0, 64'(i), 32'd1000 + i);
        tick(32'd10);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < 4; i++) ban(2'd2, 64'hABCD, 64'h100 + i, 32'd2000);
        ban(2'd1, '0, 64'd3, 32'd3000);
        tick(32'd20);
        tick(32'hFFFF_FFFF);
    endtask

    task automatic test_backpressure();
        for (int i = 0; i < 12; i++) ban(2'd1, '0, 64'h500 + i, 32'd900);
        tick(32'd100);
        // hold past the drain so the sweep stalls and bans back up at the input
        long_hold = 2000;
        for (int i = 0; i < 6; i++) ban(2'd2, {$urandom, $urandom}, {$urandom, $urandom}, 32'd950);
        tick(32'd200);
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] pool_hi[8];
        logic [ADDR_W-1:0] pool_lo[8];
        int k;
        clock_now = 32'd1000;
        for (int i = 0; i < 8; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        while (items_sent < 270) begin
            if (items_sent > 230) quiet = 1'b1;
            k = $urandom_range(0, 19);
            if (k == 0) begin
                clock_now = clock_now + $urandom_range(0, 40);
                tick(clock_now);
            end else if (k == 1) begin
                ban(FAM_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
            end else if (k == 2) begin
                tick($urandom);
                clock_now = 32'd1000;
            end else begin
                k = $urandom_range(0, 7);
                ban(FAM_W'($urandom_range(1, 2)), pool_hi[k], pool_lo[k],
                    clock_now + $urandom_range(0, 60) - 10);
            end
        end
        tick(clock_now);
    endtask

    initial begin
        int guard;
        errors = 0;
        items_sent = 0;
        quiet = 1'b0;
        long_hold = 0;
        bans_dropped = '0;
        for (int i = 0; i < DEPTH; i++) ban_slots[i] = '{'0, '0, '0, '0};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_special_cases();
        test_ring_overflow();
        test_table_full();
        test_backpressure();
        test_random_traffic();
        s_tvalid <= 1'b0;

        guard = 0;
        while (expected_decisions.size() > 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_decisions.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> ban_queue_expiring_decision_table_core.f
rtl/core/bqedt_pkg.sv
rtl/core/bqedt_ctrl.sv
rtl/core/bqedt_dp.sv
rtl/core/ban_queue_expiring_decision_table_core.sv
tb/sv/tb_ban_queue_expiring_decision_table_core.sv
